@@ hdl/ldp_pkg.sv @@
package ldp_pkg;

    // Field and register widths.
    localparam int XW     = 24;
    localparam int FW     = 24;
    localparam int PRIN_W = 48;
    localparam int KW     = 32;
    localparam int OW     = 32;
    localparam int CFG_IW = 4;
    localparam int CFG_DW = 48;

    // Internal widths, sized from the largest magnitude each value can take.
    localparam int R2W = 28;   // r^2, unsigned Q.20, at most 2^27
    localparam int R4W = 35;   // r^4, unsigned Q.20, at most 2^34
    localparam int R6W = 42;   // r^6, unsigned Q.20, at most 2^41
    localparam int A1W = 29;   // 2xy, signed Q.20
    localparam int A2W = 29;   // r^2 + 2x^2, unsigned Q.20
    localparam int CDW = 54;   // radial factor, signed Q.24
    localparam int XDW = 58;   // distorted point, signed Q.24
    localparam int UW  = 60;   // pixel coordinate before clamping, signed Q.10

    // Operand slice width of the multiply unit ldp_mulr.
    localparam int MUL_CHUNK = 31;

    localparam logic signed [KW-1:0] DIST_THRESHOLD = 32'sd167;
    localparam logic [FW-1:0]        FOCAL_RESET    = 24'd1024;
    localparam logic signed [OW-1:0] PIX_MAX        = 32'sh7FFF_FFFF;
    localparam logic signed [OW-1:0] PIX_MIN        = 32'sh8000_0000;

    typedef enum logic [CFG_IW-1:0] {
        REG_FOCAL_X       = 4'd0,
        REG_FOCAL_Y       = 4'd1,
        REG_PRINCIPAL     = 4'd2,
        REG_RADIAL_K1     = 4'd3,
        REG_RADIAL_K2     = 4'd4,
        REG_TANGENTIAL_P1 = 4'd5,
        REG_TANGENTIAL_P2 = 4'd6,
        REG_RADIAL_K3     = 4'd7
    } t_cfg_idx;

    typedef struct packed {
        logic                 en;
        logic signed [KW-1:0] k1;
        logic signed [KW-1:0] k2;
        logic signed [KW-1:0] k3;
        logic signed [KW-1:0] p1;
        logic signed [KW-1:0] p2;
    } t_coef;

endpackage

@@ hdl/ldp_delay.sv @@
module ldp_delay #(
    parameter int W = 8,
    parameter int D = 1
) (
    input  logic         i_clk,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);

    logic [W-1:0] r_q [D];

    always_ff @(posedge i_clk) begin
        r_q[0] <= i_d;
        for (int i = 1; i < D; i++) begin
            r_q[i] <= r_q[i-1];
        end
    end

    assign o_q = r_q[D-1];

endmodule

@@ hdl/ldp_mulr.sv @@
module ldp_mulr #(
    parameter int AW = 32,
    parameter int BW = 32,
    parameter int SH = 20,
    parameter int RW = 32
) (
    input  logic                 i_clk,
    input  logic signed [AW-1:0] i_a,
    input  logic signed [BW-1:0] i_b,
    output logic signed [RW-1:0] o_p
);
    import ldp_pkg::*;

    localparam int CW  = MUL_CHUNK;
    localparam int NCH = (BW + CW - 1) / CW;
    localparam int BXW = NCH * CW;
    localparam int PW  = AW + CW + 1;
    localparam int SW  = AW + BXW + 1;
    localparam logic signed [SW-1:0] RND_HALF = SW'(1) <<< (SH - 1);

    logic signed [BXW-1:0] b_ext;
    logic signed [PW-1:0]  r_pp [NCH];
    logic signed [SW-1:0]  sum_pp;
    logic signed [SW-1:0]  r_sum;
    logic signed [SW-1:0]  rnd_sum;
    logic signed [RW-1:0]  r_p;

    assign b_ext = BXW'(i_b);

    // Stage one: one partial product per slice of b; only the top slice is signed.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NCH; i++) begin
            if (i == NCH - 1) begin
                r_pp[i] <= PW'(i_a * $signed(b_ext[i*CW +: CW]));
            end else begin
                r_pp[i] <= PW'(i_a * $signed({1'b0, b_ext[i*CW +: CW]}));
            end
        end
    end

    always_comb begin
        sum_pp = '0;
        for (int i = 0; i < NCH; i++) begin
            sum_pp = sum_pp + (SW'(r_pp[i]) <<< (i * CW));
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum <= sum_pp;
    end

    // Adding half less one for negative products rounds ties away from zero.
    assign rnd_sum = r_sum + RND_HALF - $signed({{(SW-1){1'b0}}, r_sum[SW-1]});

    always_ff @(posedge i_clk) begin
        r_p <= RW'(rnd_sum >>> SH);
    end

    assign o_p = r_p;

endmodule

@@ hdl/ldp_dist.sv @@
module ldp_dist (
    input  logic                           i_clk,
    input  logic signed [ldp_pkg::XW-1:0]  i_x,
    input  logic signed [ldp_pkg::XW-1:0]  i_y,
    input  ldp_pkg::t_coef                 i_coef,
    output logic signed [ldp_pkg::XDW-1:0] o_xd,
    output logic signed [ldp_pkg::XDW-1:0] o_yd
);
    import ldp_pkg::*;

    localparam int SQW = 2 * XW;
    localparam logic [SQW:0]            HALF20   = (SQW + 1)'(1) << 19;
    localparam logic [SQW:0]            HALF19   = (SQW + 1)'(1) << 18;
    localparam logic signed [SQW-1:0]   XY_HALF  = SQW'(1) <<< 18;
    localparam logic signed [CDW-1:0]   CD_ONE   = CDW'(1) <<< 24;

    logic signed [SQW-1:0] r_xx;
    logic signed [SQW-1:0] r_yy;
    logic signed [SQW-1:0] r_xy;
    logic [SQW:0]          sq_sum;
    logic [SQW:0]          xx_rnd;
    logic [SQW:0]          yy_rnd;
    logic signed [SQW-1:0] xy_rnd;
    logic [R2W-1:0]        r_r2;
    logic [R2W-1:0]        r_axx;
    logic [R2W-1:0]        r_ayy;
    logic signed [A1W-1:0] r_a1;
    logic [A2W-1:0]        r_a2;
    logic [A2W-1:0]        r_a3;
    logic signed [R2W:0]   r2_s;
    logic [R2W:0]          r2_d3;
    logic signed [R4W:0]   w_r4;
    logic signed [R6W:0]   w_r6;
    logic signed [CDW-1:0] w_k1t;
    logic signed [CDW-1:0] w_k2t;
    logic signed [CDW-1:0] w_k3t;
    logic [CDW-1:0]        k1t_d;
    logic [CDW-1:0]        k2t_d;
    logic signed [CDW-1:0] r_cd;
    logic [XW-1:0]         x_d12;
    logic [XW-1:0]         y_d12;
    logic [XW-1:0]         x_d15;
    logic [XW-1:0]         y_d15;
    logic signed [XDW-1:0] w_xc;
    logic signed [XDW-1:0] w_yc;
    logic signed [XDW-1:0] w_ta_x;
    logic signed [XDW-1:0] w_tb_x;
    logic signed [XDW-1:0] w_ta_y;
    logic signed [XDW-1:0] w_tb_y;
    logic [XDW-1:0]        ta_x_d;
    logic [XDW-1:0]        tb_x_d;
    logic [XDW-1:0]        ta_y_d;
    logic [XDW-1:0]        tb_y_d;
    logic signed [XDW-1:0] r_xd;
    logic signed [XDW-1:0] r_yd;

    // Exact squares and cross product.
    always_ff @(posedge i_clk) begin
        r_xx <= i_x * i_x;
        r_yy <= i_y * i_y;
        r_xy <= i_x * i_y;
    end

    assign sq_sum = {1'b0, r_xx} + {1'b0, r_yy} + HALF20;
    assign xx_rnd = {1'b0, r_xx} + HALF19;
    assign yy_rnd = {1'b0, r_yy} + HALF19;
    assign xy_rnd = r_xy + XY_HALF - $signed({{(SQW-1){1'b0}}, r_xy[SQW-1]});

    always_ff @(posedge i_clk) begin
        r_r2  <= R2W'(sq_sum >> 20);
        r_axx <= R2W'(xx_rnd >> 19);
        r_ayy <= R2W'(yy_rnd >> 19);
        r_a1  <= A1W'(xy_rnd >>> 19);
        r_a2  <= A2W'(r_r2) + A2W'(r_axx);
        r_a3  <= A2W'(r_r2) + A2W'(r_ayy);
    end

    assign r2_s = $signed({1'b0, r_r2});

    // Powers of r^2 and the radial terms.
    ldp_mulr #(.AW(R2W + 1), .BW(R2W + 1), .SH(20), .RW(R4W + 1)) u_mul_r4 (
        .i_clk(i_clk), .i_a(r2_s), .i_b(r2_s), .o_p(w_r4)
    );

    ldp_mulr #(.AW(KW), .BW(R2W + 1), .SH(20), .RW(CDW)) u_mul_k1 (
        .i_clk(i_clk), .i_a($signed(i_coef.k1)), .i_b(r2_s), .o_p(w_k1t)
    );

    ldp_delay #(.W(R2W + 1), .D(3)) u_dly_r2 (
        .i_clk(i_clk), .i_d(r2_s), .o_q(r2_d3)
    );

    ldp_mulr #(.AW(R2W + 1), .BW(R4W + 1), .SH(20), .RW(R6W + 1)) u_mul_r6 (
        .i_clk(i_clk), .i_a($signed(r2_d3)), .i_b(w_r4), .o_p(w_r6)
    );

    ldp_mulr #(.AW(KW), .BW(R4W + 1), .SH(20), .RW(CDW)) u_mul_k2 (
        .i_clk(i_clk), .i_a($signed(i_coef.k2)), .i_b(w_r4), .o_p(w_k2t)
    );

    ldp_mulr #(.AW(KW), .BW(R6W + 1), .SH(20), .RW(CDW)) u_mul_k3 (
        .i_clk(i_clk), .i_a($signed(i_coef.k3)), .i_b(w_r6), .o_p(w_k3t)
    );

    ldp_delay #(.W(CDW), .D(6)) u_dly_k1t (
        .i_clk(i_clk), .i_d(w_k1t), .o_q(k1t_d)
    );

    ldp_delay #(.W(CDW), .D(3)) u_dly_k2t (
        .i_clk(i_clk), .i_d(w_k2t), .o_q(k2t_d)
    );

    always_ff @(posedge i_clk) begin
        r_cd <= CD_ONE + $signed(k1t_d) + $signed(k2t_d) + w_k3t;
    end

    // Point scaled by the radial factor.
    ldp_delay #(.W(XW), .D(12)) u_dly_x12 (.i_clk(i_clk), .i_d(i_x), .o_q(x_d12));
    ldp_delay #(.W(XW), .D(12)) u_dly_y12 (.i_clk(i_clk), .i_d(i_y), .o_q(y_d12));
    ldp_delay #(.W(XW), .D(3))  u_dly_x15 (.i_clk(i_clk), .i_d(x_d12), .o_q(x_d15));
    ldp_delay #(.W(XW), .D(3))  u_dly_y15 (.i_clk(i_clk), .i_d(y_d12), .o_q(y_d15));

    ldp_mulr #(.AW(XW), .BW(CDW), .SH(20), .RW(XDW)) u_mul_xc (
        .i_clk(i_clk), .i_a($signed(x_d12)), .i_b(r_cd), .o_p(w_xc)
    );

    ldp_mulr #(.AW(XW), .BW(CDW), .SH(20), .RW(XDW)) u_mul_yc (
        .i_clk(i_clk), .i_a($signed(y_d12)), .i_b(r_cd), .o_p(w_yc)
    );

    // Tangential terms.
    ldp_mulr #(.AW(KW), .BW(A1W), .SH(20), .RW(XDW)) u_mul_ta_x (
        .i_clk(i_clk), .i_a($signed(i_coef.p1)), .i_b(r_a1), .o_p(w_ta_x)
    );

    ldp_mulr #(.AW(KW), .BW(A2W + 1), .SH(20), .RW(XDW)) u_mul_tb_x (
        .i_clk(i_clk), .i_a($signed(i_coef.p2)), .i_b($signed({1'b0, r_a2})), .o_p(w_tb_x)
    );

    ldp_mulr #(.AW(KW), .BW(A2W + 1), .SH(20), .RW(XDW)) u_mul_ta_y (
        .i_clk(i_clk), .i_a($signed(i_coef.p1)), .i_b($signed({1'b0, r_a3})), .o_p(w_ta_y)
    );

    ldp_mulr #(.AW(KW), .BW(A1W), .SH(20), .RW(XDW)) u_mul_tb_y (
        .i_clk(i_clk), .i_a($signed(i_coef.p2)), .i_b(r_a1), .o_p(w_tb_y)
    );

    ldp_delay #(.W(XDW), .D(10)) u_dly_ta_x (.i_clk(i_clk), .i_d(w_ta_x), .o_q(ta_x_d));
    ldp_delay #(.W(XDW), .D(9))  u_dly_tb_x (.i_clk(i_clk), .i_d(w_tb_x), .o_q(tb_x_d));
    ldp_delay #(.W(XDW), .D(9))  u_dly_ta_y (.i_clk(i_clk), .i_d(w_ta_y), .o_q(ta_y_d));
    ldp_delay #(.W(XDW), .D(10)) u_dly_tb_y (.i_clk(i_clk), .i_d(w_tb_y), .o_q(tb_y_d));

    // Without distortion the point is passed on in Q.24, so the focal multiply
    // that follows gives the same rounding as a direct Q.20 product.
    always_ff @(posedge i_clk) begin
        if (i_coef.en) begin
            r_xd <= w_xc + $signed(ta_x_d) + $signed(tb_x_d);
            r_yd <= w_yc + $signed(ta_y_d) + $signed(tb_y_d);
        end else begin
            r_xd <= XDW'($signed(x_d15)) <<< 4;
            r_yd <= XDW'($signed(y_d15)) <<< 4;
        end
    end

    assign o_xd = r_xd;
    assign o_yd = r_yd;

endmodule

@@ hdl/lens_distortion_projection.sv @@
// Projects one normalised image-plane point (Q3.20) to pixel coordinates (Q21.10)
// through a pinhole model with Brown-Conrady radial and tangential distortion,
// which is applied only while radial_k1 is above 167 (1e-5 in Q8.24). The block
// is fully pipelined: a new word is taken in every cycle while busy is low, and
// busy is high only while reset is held and for the cycle after it. Each
// result is driven onto the output ports, marked by o_valid, in the order of
// acceptance; the receiver cannot stall and must take it in that cycle. The
// dependent chain runs through the input register, the squares and r^2 (two
// stages), the rounded multiplies r^4, r^6, the k3 term, the point times the
// radial factor and the focal scale (each a three-stage multiply unit), and
// single stages for the radial sum, the distorted sum, the principal point
// offset and the clamp. Coordinates outside the signed 32-bit range are
// clamped and flagged. Write the registers only while no word is in flight;
// a write to an index above seven is ignored.
module lens_distortion_projection (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [ldp_pkg::XW-1:0]     i_x_norm,
    input  logic signed [ldp_pkg::XW-1:0]     i_y_norm,
    output logic                              o_valid,
    output logic signed [ldp_pkg::OW-1:0]     o_pixel_u,
    output logic signed [ldp_pkg::OW-1:0]     o_pixel_v,
    output logic                              o_saturated,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [ldp_pkg::CFG_IW-1:0]        i_cfg_index,
    input  logic [ldp_pkg::CFG_DW-1:0]        i_cfg_data
);
    import ldp_pkg::*;

    // Register stages behind the input register.
    localparam int PIPE_LAT = 21;

    logic                  r_busy;
    logic [PIPE_LAT:0]     r_vld;
    logic [FW-1:0]         r_fx;
    logic [FW-1:0]         r_fy;
    logic [PRIN_W-1:0]     r_prin;
    logic signed [KW-1:0]  r_k1;
    logic signed [KW-1:0]  r_k2;
    logic signed [KW-1:0]  r_k3;
    logic signed [KW-1:0]  r_p1;
    logic signed [KW-1:0]  r_p2;
    t_coef                 coef;
    logic signed [XW-1:0]  r_x;
    logic signed [XW-1:0]  r_y;
    logic signed [XDW-1:0] w_xd;
    logic signed [XDW-1:0] w_yd;
    logic signed [UW-1:0]  w_u;
    logic signed [UW-1:0]  w_v;
    logic signed [UW-1:0]  r_us;
    logic signed [UW-1:0]  r_vs;
    logic                  u_ok;
    logic                  v_ok;
    logic signed [OW-1:0]  r_u;
    logic signed [OW-1:0]  r_v;
    logic                  r_sat;

    assign busy        = r_busy | ~i_rst_n;
    assign o_cfg_ready = ~busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_vld  <= '0;
            r_fx   <= FOCAL_RESET;
            r_fy   <= FOCAL_RESET;
            r_prin <= '0;
            r_k1   <= '0;
            r_k2   <= '0;
            r_k3   <= '0;
            r_p1   <= '0;
            r_p2   <= '0;
        end else begin
            r_busy <= 1'b0;
            r_vld  <= {r_vld[PIPE_LAT-1:0], start & ~busy};
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    REG_FOCAL_X:       r_fx   <= i_cfg_data[FW-1:0];
                    REG_FOCAL_Y:       r_fy   <= i_cfg_data[FW-1:0];
                    REG_PRINCIPAL:     r_prin <= i_cfg_data[PRIN_W-1:0];
                    REG_RADIAL_K1:     r_k1   <= $signed(i_cfg_data[KW-1:0]);
                    REG_RADIAL_K2:     r_k2   <= $signed(i_cfg_data[KW-1:0]);
                    REG_TANGENTIAL_P1: r_p1   <= $signed(i_cfg_data[KW-1:0]);
                    REG_TANGENTIAL_P2: r_p2   <= $signed(i_cfg_data[KW-1:0]);
                    REG_RADIAL_K3:     r_k3   <= $signed(i_cfg_data[KW-1:0]);
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        coef.en = r_k1 > DIST_THRESHOLD;
        coef.k1 = r_k1;
        coef.k2 = r_k2;
        coef.k3 = r_k3;
        coef.p1 = r_p1;
        coef.p2 = r_p2;
    end

    always_ff @(posedge i_clk) begin
        r_x <= i_x_norm;
        r_y <= i_y_norm;
    end

    ldp_dist u_dist (
        .i_clk  (i_clk),
        .i_x    (r_x),
        .i_y    (r_y),
        .i_coef (coef),
        .o_xd   (w_xd),
        .o_yd   (w_yd)
    );

    ldp_mulr #(.AW(FW + 1), .BW(XDW), .SH(24), .RW(UW)) u_mul_u (
        .i_clk(i_clk), .i_a($signed({1'b0, r_fx})), .i_b(w_xd), .o_p(w_u)
    );

    ldp_mulr #(.AW(FW + 1), .BW(XDW), .SH(24), .RW(UW)) u_mul_v (
        .i_clk(i_clk), .i_a($signed({1'b0, r_fy})), .i_b(w_yd), .o_p(w_v)
    );

    always_ff @(posedge i_clk) begin
        r_us <= w_u + UW'($signed({1'b0, r_prin[PRIN_W-1:FW]}));
        r_vs <= w_v + UW'($signed({1'b0, r_prin[FW-1:0]}));
    end

    // A value fits in 32 bits when everything above bit 30 is a copy of the sign.
    assign u_ok = (&r_us[UW-1:OW-1]) | ~(|r_us[UW-1:OW-1]);
    assign v_ok = (&r_vs[UW-1:OW-1]) | ~(|r_vs[UW-1:OW-1]);

    always_ff @(posedge i_clk) begin
        r_u   <= u_ok ? r_us[OW-1:0] : (r_us[UW-1] ? PIX_MIN : PIX_MAX);
        r_v   <= v_ok ? r_vs[OW-1:0] : (r_vs[UW-1] ? PIX_MIN : PIX_MAX);
        r_sat <= ~u_ok | ~v_ok;
    end

    assign o_valid     = r_vld[PIPE_LAT];
    assign o_pixel_u   = r_u;
    assign o_pixel_v   = r_v;
    assign o_saturated = r_sat;

endmodule

@@ hdl/ldp_chk.sv @@
module ldp_chk (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic                          o_valid,
    input  logic signed [ldp_pkg::OW-1:0] o_pixel_u,
    input  logic signed [ldp_pkg::OW-1:0] o_pixel_v,
    input  logic                          o_saturated
);
    import ldp_pkg::*;

    localparam int LAT = 22;

    // Every accepted word produces a result.
    a_word_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_valid)
        else $error("accepted word produced no result");

    // No result appears without a matching accepted word.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LAT))
        else $error("result without a matching accepted word");

    // A flagged result must carry at least one clamped coordinate.
    a_sat_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_saturated) |->
            (o_pixel_u == PIX_MAX || o_pixel_u == PIX_MIN ||
             o_pixel_v == PIX_MAX || o_pixel_v == PIX_MIN))
        else $error("saturation flag set on an unclamped result");

    // The block is ready for words in the cycle after reset is released.
    a_ready_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |=> !busy)
        else $error("busy held after reset release");

endmodule

bind lens_distortion_projection ldp_chk u_ldp_chk (.*);
